// ===== rtl/frx_pkg.sv =====
// shared types and constants of the frame receiver with xor checksum
// no dependencies; every other file imports this package
package frx_pkg;

  localparam int unsigned MaxPayload = 256;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned LenW       = 9;
  localparam int unsigned PosW       = $clog2(MaxPayload + 1);
  localparam int unsigned IdxW       = 8;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [LenW-1:0]  LenSat          = '1;
  localparam logic [ByteW-1:0] StartMarkerRst  = 8'hA5;
  localparam logic [ByteW-1:0] EndMarkerRst    = 8'h5A;

  localparam logic [CfgIdxW-1:0] CfgStartMarker = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEndMarker   = 2'd1;

  typedef enum logic [2:0] {
    PhSop  = 3'd0,
    PhCmd  = 3'd1,
    PhLen1 = 3'd2,
    PhLen2 = 3'd3,
    PhData = 3'd4,
    PhCsum = 3'd5,
    PhEop  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    EvNone = 3'd0,
    EvData = 3'd1,
    EvGood = 3'd2,
    EvCsum = 3'd3,
    EvEop  = 3'd4,
    EvLong = 3'd5
  } event_e;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] end_marker;
  } frx_cfg_t;

  typedef struct packed {
    event_e           event_res;
    logic [ByteW-1:0] command;
    logic [LenW-1:0]  frame_length;
    logic [ByteW-1:0] data_byte;
    logic [IdxW-1:0]  data_index;
  } frx_result_t;

endpackage

// ===== rtl/frx_cfg_regs.sv =====
// marker configuration registers, written over the config channel
// depends on frx_pkg
module frx_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [frx_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [frx_pkg::ByteW-1:0]    cfg_data_i,
  output frx_pkg::frx_cfg_t            cfg_o
);
  import frx_pkg::*;

  frx_cfg_t cfg_q;

  // indexes beyond the register list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= StartMarkerRst;
      cfg_q.end_marker   <= EndMarkerRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgStartMarker: cfg_q.start_marker <= cfg_data_i;
        CfgEndMarker:   cfg_q.end_marker   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/frx_parser.sv =====
// frame parser state and per-beat next-state/result logic
// depends on frx_pkg
module frx_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [frx_pkg::ByteW-1:0]  rx_byte_i,
  input  frx_pkg::frx_cfg_t          cfg_i,
  output frx_pkg::frx_result_t       res_o
);
  import frx_pkg::*;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [15:0]      full_len;

  // full 16-bit length once the high byte arrives
  assign full_len = {rx_byte_i, len_q[ByteW-1:0]};

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    pos_d   = pos_q;
    xor_d   = xor_q;
    res_o.event_res  = EvNone;
    res_o.data_byte  = '0;
    res_o.data_index = '0;
    case (phase_q)
      PhSop: begin
        if (rx_byte_i == cfg_i.start_marker) begin
          xor_d   = '0;
          phase_d = PhCmd;
        end
      end
      PhCmd: begin
        cmd_d   = rx_byte_i;
        xor_d   = xor_q ^ rx_byte_i;
        phase_d = PhLen1;
      end
      PhLen1: begin
        len_d   = {1'b0, rx_byte_i};
        xor_d   = xor_q ^ rx_byte_i;
        phase_d = PhLen2;
      end
      PhLen2: begin
        xor_d = xor_q ^ rx_byte_i;
        // held length is kept saturated, which is all the outputs ever show
        len_d = (full_len > 16'(LenSat)) ? LenSat : full_len[LenW-1:0];
        if (full_len > 16'(MaxPayload)) begin
          res_o.event_res = EvLong;
          phase_d         = PhSop;
        end else if (full_len == '0) begin
          phase_d = PhCsum;
        end else begin
          pos_d   = '0;
          phase_d = PhData;
        end
      end
      PhData: begin
        res_o.event_res  = EvData;
        res_o.data_byte  = rx_byte_i;
        res_o.data_index = pos_q[IdxW-1:0];
        xor_d            = xor_q ^ rx_byte_i;
        pos_d            = pos_q + PosW'(1);
        if (LenW'(pos_d) >= len_q) phase_d = PhCsum;
      end
      PhCsum: begin
        if (rx_byte_i == xor_q) begin
          phase_d = PhEop;
        end else begin
          res_o.event_res = EvCsum;
          phase_d         = PhSop;
        end
      end
      PhEop: begin
        res_o.event_res = (rx_byte_i == cfg_i.end_marker) ? EvGood : EvEop;
        phase_d         = PhSop;
      end
      default: begin
        phase_d = PhSop;
      end
    endcase
    res_o.command      = cmd_d;
    res_o.frame_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSop;
      cmd_q   <= '0;
      len_q   <= '0;
      pos_q   <= '0;
      xor_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      xor_q   <= xor_d;
    end
  end

endmodule

// ===== rtl/frx_out_reg.sv =====
// result register with valid flag between parser and output channel
// depends on frx_pkg
module frx_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  frx_pkg::frx_result_t  res_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output frx_pkg::frx_result_t  res_o
);
  import frx_pkg::*;

  logic        valid_q;
  frx_result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/frame_receiver_xor_checksum_unit.sv =====
// channel  | direction | signals
// in       | sink      | in_valid_i, in_ready_o, rx_byte_i
// out      | source    | out_valid_o, out_ready_i, event_res_o, command_o, frame_length_o,
//          |           | data_byte_o, data_index_o
// cfg      | sink      | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// one byte per cycle while in_ready_o is high; its result appears in the output register the cycle after the beat
// parser state updates in the same cycle a byte is taken, so bytes stream back to back
// in_ready_o drops only while a result sits unread and out_ready_i is low
// reset returns the parser to hunting for a start marker and restores the markers
// top level: frame parser with xor checksum; depends on frx_pkg, frx_cfg_regs,
// frx_parser and frx_out_reg
module frame_receiver_xor_checksum_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [frx_pkg::ByteW-1:0]    rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   event_res_o,
  output logic [frx_pkg::ByteW-1:0]    command_o,
  output logic [frx_pkg::LenW-1:0]     frame_length_o,
  output logic [frx_pkg::ByteW-1:0]    data_byte_o,
  output logic [frx_pkg::IdxW-1:0]     data_index_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [frx_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [frx_pkg::ByteW-1:0]    cfg_data_i
);
  import frx_pkg::*;

  frx_cfg_t    cfg;
  frx_result_t res_next;
  frx_result_t res_out;
  logic        accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_o || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  frx_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  frx_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg),
    .res_o     (res_next)
  );

  frx_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res_next),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign event_res_o    = res_out.event_res;
  assign command_o      = res_out.command;
  assign frame_length_o = res_out.frame_length;
  assign data_byte_o    = res_out.data_byte;
  assign data_index_o   = res_out.data_index;

endmodule

// ===== rtl/frx_checker.sv =====
// port-level checks on the frame receiver, attached by bind
// depends on frx_pkg and frame_receiver_xor_checksum_unit
module frx_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_o,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [2:0]                  event_res_o,
  input  logic [frx_pkg::ByteW-1:0]   command_o,
  input  logic [frx_pkg::LenW-1:0]    frame_length_o,
  input  logic [frx_pkg::ByteW-1:0]   data_byte_o,
  input  logic [frx_pkg::IdxW-1:0]    data_index_o
);
  import frx_pkg::*;

  // a held result keeps its beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_res_o)
      && $stable(command_o) && $stable(frame_length_o)
      && $stable(data_byte_o) && $stable(data_index_o))
    else $error("held result changed");

  // every accepted byte shows up as a result next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted byte produced no result");

  // an empty output register never stalls the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // payload fields are zero outside payload beats
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EvData |-> data_byte_o == '0 && data_index_o == '0)
    else $error("payload fields set on non-payload event");

  // a payload beat belongs to a frame within the buffer size
  a_data_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EvData
      |-> frame_length_o <= LenW'(MaxPayload) && frame_length_o != '0)
    else $error("payload beat with bad frame length");

endmodule

bind frame_receiver_xor_checksum_unit frx_checker u_frx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .event_res_o    (event_res_o),
  .command_o      (command_o),
  .frame_length_o (frame_length_o),
  .data_byte_o    (data_byte_o),
  .data_index_o   (data_index_o)
);

// ===== test/frx_frame_checker.sv =====
// frame checker for the frame receiver: watches the byte, result and register channels,
// predicts the event of every byte and compares it with the block's results
// depends on frx_pkg
module frx_frame_checker
  import frx_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [2:0]         event_res_i,
  input  logic [ByteW-1:0]   command_i,
  input  logic [LenW-1:0]    frame_length_i,
  input  logic [ByteW-1:0]   data_byte_i,
  input  logic [IdxW-1:0]    data_index_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 good_frames_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ByteW-1:0] sof_marker;
  logic [ByteW-1:0] eof_marker;
  phase_e           phase;
  logic [ByteW-1:0] cmd_q;
  logic [15:0]      len_q;
  logic [15:0]      pos_q;
  logic [ByteW-1:0] xor_acc;

  frx_result_t expected_events[$];
  int          errors;
  int          checked;
  int          good_frames;

  assign fail_count_o  = errors;
  assign checked_o     = checked;
  assign good_frames_o = good_frames;

  // advances the parser copy by one byte and returns the event it causes
  function automatic frx_result_t parse_rx_byte(input logic [ByteW-1:0] b);
    frx_result_t r;
    r = '0;
    r.event_res = EvNone;
    case (phase)
      PhSop: begin
        if (b == sof_marker) begin
          xor_acc = '0;
          phase   = PhCmd;
        end
      end
      PhCmd: begin
        cmd_q   = b;
        xor_acc = xor_acc ^ b;
        phase   = PhLen1;
      end
      PhLen1: begin
        len_q   = {8'h00, b};
        xor_acc = xor_acc ^ b;
        phase   = PhLen2;
      end
      PhLen2: begin
        len_q[15:8] = b;
        xor_acc     = xor_acc ^ b;
        if (32'(len_q) > MaxPayload) begin
          r.event_res = EvLong;
          phase       = PhSop;
        end else if (len_q == 16'd0) begin
          phase = PhCsum;
        end else begin
          pos_q = '0;
          phase = PhData;
        end
      end
      PhData: begin
        r.event_res  = EvData;
        r.data_byte  = b;
        r.data_index = pos_q[IdxW-1:0];
        xor_acc      = xor_acc ^ b;
        pos_q        = pos_q + 16'd1;
        if (pos_q >= len_q) phase = PhCsum;
      end
      PhCsum: begin
        if (b == xor_acc) begin
          phase = PhEop;
        end else begin
          r.event_res = EvCsum;
          phase       = PhSop;
        end
      end
      PhEop: begin
        r.event_res = (b == eof_marker) ? EvGood : EvEop;
        phase       = PhSop;
      end
      default: phase = PhSop;
    endcase
    r.command      = cmd_q;
    r.frame_length = (len_q > 16'(LenSat)) ? LenSat : len_q[LenW-1:0];
    return r;
  endfunction

  task automatic flag_field(input string field, input int unsigned want,
                            input int unsigned seen);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
    errors++;
  endtask

  always @(posedge clk_i) begin
    frx_result_t want;
    frx_result_t seen;
    if (!rst_ni) begin
      sof_marker = StartMarkerRst;
      eof_marker = EndMarkerRst;
      phase      = PhSop;
      cmd_q      = '0;
      len_q      = '0;
      pos_q      = '0;
      xor_acc    = '0;
      expected_events.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgStartMarker) sof_marker = cfg_data_i;
        else if (cfg_index_i == CfgEndMarker) eof_marker = cfg_data_i;
      end
      // results are checked before this edge's byte is predicted
      if (out_valid_i && out_ready_i) begin
        seen.event_res    = event_e'(event_res_i);
        seen.command      = command_i;
        seen.frame_length = frame_length_i;
        seen.data_byte    = data_byte_i;
        seen.data_index   = data_index_i;
        if (expected_events.size() == 0) begin
          $display("%0t: result beat with nothing expected, event %0d", $time, event_res_i);
          errors++;
        end else begin
          want = expected_events.pop_front();
          checked++;
          if (want.event_res == EvGood) good_frames++;
          if (seen.event_res !== want.event_res)
            flag_field("event_res", want.event_res, event_res_i);
          if (seen.command !== want.command)
            flag_field("command", want.command, seen.command);
          if (seen.frame_length !== want.frame_length)
            flag_field("frame_length", want.frame_length, seen.frame_length);
          if (seen.data_byte !== want.data_byte)
            flag_field("data_byte", want.data_byte, seen.data_byte);
          if (seen.data_index !== want.data_index)
            flag_field("data_index", want.data_index, seen.data_index);
        end
      end
      if (in_valid_i && in_ready_i) expected_events.push_back(parse_rx_byte(rx_byte_i));
    end
    pending_o <= expected_events.size();
  end

endmodule

// ===== test/frame_receiver_xor_checksum_unit_test.sv =====
// testbench top of the frame receiver: drives bytes, result stalls and marker writes
// under several handshake mixes; depends on frx_pkg, frx_frame_checker and the block
module frame_receiver_xor_checksum_unit_test;
  import frx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit    = 400000;
  localparam int BytesPerMix   = 75;
  localparam int SettleCycles  = 4;

  // indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  typedef enum {FrameClean, FrameBadSum, FrameBadEnd, FrameCut} frame_fault_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic [ByteW-1:0]   rx_byte = '0;
  logic               out_ready = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ByteW-1:0]   cfg_data = '0;

  logic               in_ready;
  logic               out_valid;
  logic [2:0]         event_res;
  logic [ByteW-1:0]   command;
  logic [LenW-1:0]    frame_length;
  logic [ByteW-1:0]   data_byte;
  logic [IdxW-1:0]    data_index;
  logic               cfg_ready;

  int fail_count;
  int pending;
  int checked;
  int good_frames;

  int               cycles = 0;
  int               sent_bytes = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  logic [ByteW-1:0] sof = StartMarkerRst;
  logic [ByteW-1:0] eof = EndMarkerRst;

  frame_receiver_xor_checksum_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .event_res_o    (event_res),
    .command_o      (command),
    .frame_length_o (frame_length),
    .data_byte_o    (data_byte),
    .data_index_o   (data_index),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  frx_frame_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .event_res_i    (event_res),
    .command_i      (command),
    .frame_length_i (frame_length),
    .data_byte_i    (data_byte),
    .data_index_i   (data_index),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .good_frames_o  (good_frames)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // valid stays high between back to back beats, it only drops for an idle gap
  task automatic push_byte(input logic [ByteW-1:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (!in_ready);
    sent_bytes++;
  endtask

  task automatic send_frame(input logic [ByteW-1:0] cmd, input logic [15:0] len,
                            input frame_fault_e fault);
    logic [ByteW-1:0] head[4];
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    int               cut;
    head[0] = sof;
    head[1] = cmd;
    head[2] = len[7:0];
    head[3] = len[15:8];
    sum     = cmd ^ len[7:0] ^ len[15:8];
    cut     = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) begin
      push_byte(head[i]);
      if (fault == FrameCut && i + 1 == cut) return;
    end
    if (32'(len) > MaxPayload) return;
    for (int i = 0; i < int'(len); i++) begin
      b   = $urandom_range(255);
      sum = sum ^ b;
      push_byte(b);
    end
    if (fault == FrameBadSum) begin
      push_byte(sum ^ 8'($urandom_range(1, 255)));
      return;
    end
    push_byte(sum);
    push_byte(fault == FrameBadEnd ? eof ^ 8'($urandom_range(1, 255)) : eof);
  endtask

  // waits until every result is back, then lets the output register settle
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CfgStartMarker) sof = data;
    else if (idx == CfgEndMarker) eof = data;
    @(posedge clk_i);
  endtask

  task automatic random_frames(input int budget, input bit force_longest);
    int           first_bytes;
    int           r;
    logic [15:0]  len;
    frame_fault_e fault;
    first_bytes = sent_bytes;
    while (sent_bytes - first_bytes < budget) begin
      // line noise between frames, rarely
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
      end
      r = $urandom_range(99);
      if (force_longest) len = 16'(MaxPayload);
      else if (r < 3) len = 16'(MaxPayload);
      else if (r < 8) len = 16'($urandom_range(MaxPayload + 1, 65535));
      else if (r < 20) len = 16'($urandom_range(9, 64));
      else len = 16'($urandom_range(0, 8));
      force_longest = 1'b0;
      r = $urandom_range(99);
      if (r < 8) fault = FrameBadSum;
      else if (r < 16) fault = FrameBadEnd;
      else if (r < 21) fault = FrameCut;
      else fault = FrameClean;
      send_frame(8'($urandom_range(255)), len, fault);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hunting ignores other bytes
    push_byte(8'h00);
    push_byte(8'hFF);
    send_frame(8'h00, 16'h0000, FrameClean);
    send_frame(8'hFF, 16'h0001, FrameBadEnd);
    send_frame(8'h3C, 16'h0000, FrameBadSum);
    // saturated length, then one past the buffer size
    send_frame(8'h81, 16'hFFFF, FrameClean);
    send_frame(8'h7E, 16'h0101, FrameClean);

    for (int mix = 0; mix < 4; mix++) begin
      settle();
      case (mix)
        0: begin
          write_reg(CfgStartMarker, 8'h00);
          write_reg(CfgEndMarker, 8'hFF);
          write_reg(CfgSpareLo, 8'($urandom_range(255)));
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_reg(CfgStartMarker, 8'hFF);
          write_reg(CfgEndMarker, 8'h00);
          write_reg(CfgSpareHi, 8'($urandom_range(255)));
          send_idle_pct  = 80;
          recv_stall_pct = 0;
        end
        2: begin
          write_reg(CfgStartMarker, 8'($urandom_range(255)));
          write_reg(CfgEndMarker, 8'($urandom_range(255)));
          send_idle_pct  = 0;
          recv_stall_pct = 80;
        end
        default: begin
          write_reg(CfgStartMarker, StartMarkerRst);
          write_reg(CfgEndMarker, EndMarkerRst);
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
      endcase
      random_frames(BytesPerMix, mix == 0);
    end

    settle();
    $display("%0d bytes driven under four handshake mixes and five marker settings",
             sent_bytes);
    $display("%0d results checked, %0d of them good frames", checked, good_frames);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== frame_receiver_xor_checksum_unit.f =====
rtl/frx_pkg.sv
rtl/frx_cfg_regs.sv
rtl/frx_parser.sv
rtl/frx_out_reg.sv
rtl/frame_receiver_xor_checksum_unit.sv
rtl/frx_checker.sv
test/frx_frame_checker.sv
test/frame_receiver_xor_checksum_unit_test.sv
